>>> design/adp_pkg.sv
// Shared types and constants for the ASCII decimal feature parser.
// No dependencies; every other design file refers to this package by scoped name.
`default_nettype none

package adp_pkg;

  localparam int FEATURES = 8;
  localparam int LEVELS   = 8;  // power of two; level is the sequence index modulo LEVELS

  localparam int CHAR_W   = 8;
  localparam int LIMIT_W  = 7;
  localparam int VALUE_W  = 16;
  localparam int INDEX_W  = 7;
  localparam int SEQ_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_CODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_SKIP = 2'd2;

  localparam logic [CHAR_W-1:0] START_CODE_RST = 8'd115;
  localparam logic [CHAR_W-1:0] DATA_CODE_RST  = 8'd100;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'd57;

  localparam logic [SEQ_W-1:0]   SEQ_RST      = 16'd1;
  localparam logic [INDEX_W-1:0] FEATURES_IDX = INDEX_W'(FEATURES);
  localparam logic [SEQ_W-1:0]   LEVELS_SEQ   = SEQ_W'(LEVELS);

  typedef struct packed {
    logic [CHAR_W-1:0]  char_code;
    logic [LIMIT_W-1:0] level_limit;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] feature_value;
    logic [INDEX_W-1:0]        feature_index;
    logic                      feature_valid;
    logic                      vector_done;
    logic [SEQ_W-1:0]          sequence_index;
  } out_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] start_code;
    logic [CHAR_W-1:0] data_code;
    logic              stride_skip_enable;
  } cfg_t;

endpackage

`default_nettype wire

>>> design/adp_cfg_regs.sv
// Configuration registers of the ASCII decimal feature parser.
// Depends on adp_pkg.
`default_nettype none

module adp_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [adp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [adp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output adp_pkg::cfg_t                         cfg
);

  adp_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        adp_pkg::CFG_START_CODE:  cfg_nxt.start_code = cfg_data;
        adp_pkg::CFG_DATA_CODE:   cfg_nxt.data_code = cfg_data;
        adp_pkg::CFG_STRIDE_SKIP: cfg_nxt.stride_skip_enable = cfg_data[0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code         <= adp_pkg::START_CODE_RST;
      cfg_r.data_code          <= adp_pkg::DATA_CODE_RST;
      cfg_r.stride_skip_enable <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> design/adp_core.sv
// Parser state (accumulator, field counter, sign, sequence counter) and the
// per-character update logic. Depends on adp_pkg.
`default_nettype none

module adp_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire adp_pkg::in_item_t item,
  input  wire adp_pkg::cfg_t     cfg,
  output logic            emit,
  output adp_pkg::out_item_t result
);

  logic [adp_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  logic [adp_pkg::INDEX_W-1:0] field_r, field_nxt;
  logic                        neg_r, neg_nxt;
  logic [adp_pkg::SEQ_W-1:0]   seq_r, seq_nxt;

  logic is_start, is_data, is_sep, is_minus, is_digit;
  logic [adp_pkg::VALUE_W-1:0] acc_x10, digit_val, value;
  logic [adp_pkg::INDEX_W-1:0] idx, field_inc;
  logic [adp_pkg::SEQ_W-1:0]   level, seq_base;
  logic                        done;

  always_comb begin
    is_start = (item.char_code == cfg.start_code);
    is_data  = (item.char_code == cfg.data_code);
    is_sep   = (item.char_code == adp_pkg::CH_SPACE) ||
               (item.char_code == adp_pkg::CH_NEWLINE);
    is_minus = (item.char_code == adp_pkg::CH_MINUS);
    is_digit = (item.char_code >= adp_pkg::CH_ZERO) &&
               (item.char_code <= adp_pkg::CH_NINE);

    // acc * 10 as two shifts and one add, wrapping at 16 bits
    acc_x10   = (acc_r << 3) + (acc_r << 1);
    digit_val = adp_pkg::VALUE_W'(item.char_code - adp_pkg::CH_ZERO);

    value = neg_r ? (~acc_r + 1'b1) : acc_r;
    idx   = (field_r > adp_pkg::FEATURES_IDX) ? adp_pkg::FEATURES_IDX : field_r;
    field_inc = (idx < adp_pkg::FEATURES_IDX) ? idx + 1'b1 : adp_pkg::FEATURES_IDX;

    level    = seq_r % adp_pkg::LEVELS_SEQ;
    seq_base = (cfg.stride_skip_enable &&
                (level > adp_pkg::SEQ_W'(item.level_limit)))
             ? seq_r + adp_pkg::LEVELS_SEQ - level : seq_r;

    done = (item.char_code == adp_pkg::CH_NEWLINE) &&
           (field_inc >= adp_pkg::FEATURES_IDX);

    acc_nxt   = acc_r;
    field_nxt = field_r;
    neg_nxt   = neg_r;
    seq_nxt   = seq_r;
    emit      = 1'b0;

    if (is_start || is_data) begin
      acc_nxt   = '0;
      field_nxt = '0;
      neg_nxt   = 1'b0;
      if (is_start) seq_nxt = '0;
    end else if (is_sep) begin
      emit      = 1'b1;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      field_nxt = field_inc;
      if (done) seq_nxt = seq_base + 1'b1;
    end else if (is_minus) begin
      neg_nxt = 1'b1;
    end else if (is_digit) begin
      acc_nxt = acc_x10 + digit_val;
    end

    result.feature_value  = value;
    result.feature_index  = idx;
    result.feature_valid  = (idx < adp_pkg::FEATURES_IDX);
    result.vector_done    = done;
    result.sequence_index = seq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      field_r <= '0;
      neg_r   <= 1'b0;
      seq_r   <= adp_pkg::SEQ_RST;
    end else if (step) begin
      acc_r   <= acc_nxt;
      field_r <= field_nxt;
      neg_r   <= neg_nxt;
      seq_r   <= seq_nxt;
    end
  end

`ifndef SYNTHESIS
  a_field_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    field_r <= adp_pkg::FEATURES_IDX)
    else $error("field counter past FEATURES");

  a_start_clears_seq: assert property (@(posedge clk) disable iff (!rst_n)
    step && is_start |=> seq_r == '0 && field_r == '0 && acc_r == '0)
    else $error("start code did not clear state");

  a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    emit && result.vector_done |->
      result.feature_index >= adp_pkg::FEATURES_IDX - 1'b1)
    else $error("vector done before last feature");
`endif

endmodule

`default_nettype wire

>>> design/ascii_decimal_feature_parser.sv
// Top level of the ASCII decimal feature parser: input register, parser core,
// configuration registers and result register. Depends on adp_pkg, adp_cfg_regs, adp_core.
`default_nettype none

// One character is taken per clock cycle, sustained, when the result side does
// not stall. An accepted character lands in the input register; the core then
// updates its state in a single pass (multiply by ten via two shifts and an
// add), and a space or newline loads the result register once that register is
// free, from where the result is offered. Characters that give no result pass
// through even while a finished result waits to be taken.
// Configuration writes take effect at once and are meant for idle periods.
module ascii_decimal_feature_parser (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire adp_pkg::in_item_t                in_item,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output adp_pkg::out_item_t                    out_item,
  input  wire logic                             cfg_we,
  input  wire logic [adp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [adp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  adp_pkg::cfg_t      cfg;
  adp_pkg::in_item_t  s1_item_r, s1_item_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  adp_pkg::out_item_t out_item_r, out_item_nxt;
  logic               out_valid_r, out_valid_nxt;
  adp_pkg::out_item_t result;
  logic               emit, go, out_free, in_take;

  adp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  adp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (go),
    .item   (s1_item_r),
    .cfg    (cfg),
    .emit   (emit),
    .result (result)
  );

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    go       = s1_valid_r && (!emit || out_free);
    in_stall = s1_valid_r && !go;
    in_take  = in_valid && !in_stall;

    s1_valid_nxt = in_take || (s1_valid_r && !go);
    s1_item_nxt  = in_take ? in_item : s1_item_r;

    out_valid_nxt = (go && emit) || (out_valid_r && out_stall);
    out_item_nxt  = (go && emit) ? result : out_item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s1_item_r  <= s1_item_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && emit && !out_free)
    else $error("input stalled without a blocked result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_item_r))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
